/* rtl/core/kmp_stream_matcher_macros.svh */
// assertion macros shared by the matcher rtl
// no dependencies; included by the modules that carry assertions
`ifndef KMP_STREAM_MATCHER_MACROS_SVH
`define KMP_STREAM_MATCHER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define KMP_ASSERT_IMPLY(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("kmp assertion failed");

// condition holds in the cycle after the trigger
`define KMP_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("kmp assertion failed");

`endif

/* rtl/core/kmp_pkg.sv */
// types and constants of the streaming kmp matcher
// no dependencies; imported by every matcher module
package kmp_pkg;

   localparam int TEXT_W      = 8;
   localparam int START_W     = 16;
   localparam int PATTERN_W   = 64;
   localparam int LENGTH_W    = 4;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // register index codes (paddr bit 3)
   localparam logic CSR_IDX_PATTERN = 1'b0;
   localparam logic CSR_IDX_LENGTH  = 1'b1;

   typedef struct packed {
      logic [TEXT_W-1:0] text_byte;
      logic              text_last;
   } kmp_req_type;

   typedef struct packed {
      logic               match_found;
      logic [START_W-1:0] match_start;
      logic               result_last;
   } kmp_rsp_type;

   typedef enum logic [1:0] {
      BUILD_INIT,
      BUILD_STEP,
      BUILD_DONE
   } kmp_build_state_type;

endpackage

/* rtl/core/kmp_stream_matcher.sv */
// streaming kmp matcher: one result per text byte, via the front queue and result register
// throughput one byte per cycle unless rsp_ready stalls; back-end kmp step and result register set the pace
// after reset and after every register write the failure table is rebuilt, one walk step per
// cycle, and no request is taken until it is done
// reset is synchronous: clears queue, partial index, position and result valid
// depends on kmp_pkg, kmp_table_build, kmp_front, kmp_back
module kmp_stream_matcher #(
   parameter int MAX_PATTERN   = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  kmp_pkg::kmp_req_type           req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output kmp_pkg::kmp_rsp_type           rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kmp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kmp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kmp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import kmp_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_PATTERN + 1);

   logic [PATTERN_W-1:0] pattern_ff;
   logic [LENGTH_W-1:0]  length_ff;
   logic [CNT_BITS-1:0]  eff_len;
   logic                 csr_write;
   logic                 build_busy;
   logic                 q_valid;
   logic                 q_ready;
   logic [MAX_PATTERN-1:0] q_eq;
   logic                 q_last;
   logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] chain;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= LENGTH_W'(1);
      end else if (csr_write) begin
         case (csr_paddr[3])
            CSR_IDX_PATTERN: pattern_ff <= csr_pwdata;
            CSR_IDX_LENGTH:  length_ff  <= csr_pwdata[LENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr[3])
         CSR_IDX_PATTERN: csr_prdata = pattern_ff;
         CSR_IDX_LENGTH:  csr_prdata = CSR_DATA_W'(length_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // length in use: zero reads as one, clamp at the maximum
   always_comb begin
      if (length_ff == '0) begin
         eff_len = CNT_BITS'(1);
      end else if (length_ff > LENGTH_W'(MAX_PATTERN)) begin
         eff_len = CNT_BITS'(MAX_PATTERN);
      end else begin
         eff_len = CNT_BITS'(length_ff);
      end
   end

   kmp_table_build #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_build (
      .clock         (clock),
      .reset         (reset),
      .start         (csr_write),
      .pattern_bytes (pattern_ff),
      .eff_len       (eff_len),
      .chain         (chain),
      .busy          (build_busy)
   );

   kmp_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .pattern_bytes (pattern_ff),
      .build_busy    (build_busy),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_eq          (q_eq),
      .q_last        (q_last)
   );

   kmp_back #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_eq        (q_eq),
      .q_last      (q_last),
      .chain       (chain),
      .eff_len     (eff_len),
      .cfg_clear   (csr_write),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/core/kmp_table_build.sv */
// failure table builder: walks the pattern one step per cycle
// depends on kmp_pkg; produces the fallback chain masks used by kmp_back
`include "kmp_stream_matcher_macros.svh"

module kmp_table_build #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [kmp_pkg::PATTERN_W-1:0]         pattern_bytes,
   input  logic [$clog2(MAX_PATTERN+1)-1:0]      eff_len,
   output logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] chain,
   output logic                                  busy
);
   import kmp_pkg::*;

   localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_BITS = $clog2(MAX_PATTERN + 1);

   kmp_build_state_type state_ff, state_in;
   logic [IDX_BITS-1:0] i_ff, i_in;
   logic [IDX_BITS-1:0] j_ff, j_in;
   logic                jnone_ff, jnone_in;

   logic [MAX_PATTERN-1:0][IDX_BITS-1:0]    fail_idx_ff;
   logic [MAX_PATTERN-1:0]                  fail_none_ff;
   logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] chain_ff;

   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [IDX_BITS-1:0]    wr_idx;
   logic                   wr_none;
   logic [MAX_PATTERN-1:0] wr_chain;
   logic [TEXT_W-1:0]      pat_i;
   logic [TEXT_W-1:0]      pat_j;
   logic [CNT_BITS-1:0]    i_next_cnt;

   // pattern bytes at both walk pointers
   assign pat_i      = pattern_bytes[TEXT_W*i_ff +: TEXT_W];
   assign pat_j      = pattern_bytes[TEXT_W*j_ff +: TEXT_W];
   assign i_next_cnt = CNT_BITS'(i_ff) + CNT_BITS'(1);

   // state register and walk pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BUILD_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      jnone_ff <= jnone_in;
      if (wr_en) begin
         fail_idx_ff[wr_addr]  <= wr_idx;
         fail_none_ff[wr_addr] <= wr_none;
         chain_ff[wr_addr]     <= wr_chain;
      end
   end

   // one step of the border walk per cycle
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      jnone_in = jnone_ff;
      wr_en    = 1'b0;
      wr_addr  = i_ff;
      wr_idx   = '0;
      wr_none  = 1'b0;
      wr_chain = '0;
      case (state_ff)
         BUILD_INIT: begin
            i_in     = '0;
            j_in     = '0;
            jnone_in = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_none  = 1'b1;
            wr_chain = MAX_PATTERN'(1);
            state_in = BUILD_STEP;
         end
         BUILD_STEP: begin
            if (i_next_cnt >= eff_len) begin
               state_in = BUILD_DONE;
            end else if (jnone_ff || (pat_i == pat_j)) begin
               // extend the border; chain of i is i plus the chain of its fallback
               i_in     = i_ff + IDX_BITS'(1);
               j_in     = jnone_ff ? '0 : j_ff + IDX_BITS'(1);
               jnone_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = i_in;
               wr_idx   = j_in;
               wr_none  = 1'b0;
               wr_chain = (MAX_PATTERN'(1) << i_in) | chain_ff[j_in];
            end else begin
               j_in     = fail_idx_ff[j_ff];
               jnone_in = fail_none_ff[j_ff];
            end
         end
         BUILD_DONE: begin
            state_in = BUILD_DONE;
         end
         default: begin
            state_in = BUILD_INIT;
         end
      endcase
      if (start) begin
         state_in = BUILD_INIT;
      end
   end

   assign chain = chain_ff;
   assign busy  = (state_ff != BUILD_DONE);

   // finished table stays put until the next register write
   `KMP_ASSERT_NEXT(a_build_done_holds, clock, reset, (state_ff == BUILD_DONE) && !start, state_ff == BUILD_DONE)

endmodule

/* rtl/core/kmp_front.sv */
// front end: accepts text requests, compares each byte against all pattern bytes
// depends on kmp_pkg; feeds a two-entry queue read by kmp_back
`include "kmp_stream_matcher_macros.svh"

module kmp_front #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kmp_pkg::kmp_req_type          req_payload,
   input  logic [kmp_pkg::PATTERN_W-1:0] pattern_bytes,
   input  logic                          build_busy,
   output logic                          q_valid,
   input  logic                          q_ready,
   output logic [MAX_PATTERN-1:0]        q_eq,
   output logic                          q_last
);
   import kmp_pkg::*;

   logic [QUEUE_DEPTH-1:0][MAX_PATTERN-1:0] eq_q_ff;
   logic [QUEUE_DEPTH-1:0]                  last_q_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [MAX_PATTERN-1:0] eq_vec;
   logic                   push;
   logic                   pop;

   // classify the byte against every pattern position
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         eq_vec[k] = (req_payload.text_byte == pattern_bytes[TEXT_W*k +: TEXT_W]);
      end
   end

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH)) && !build_busy;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_eq      = eq_q_ff[rd_ptr_ff];
   assign q_last    = last_q_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         eq_q_ff[wr_ptr_ff]   <= eq_vec;
         last_q_ff[wr_ptr_ff] <= req_payload.text_last;
      end
   end

   `KMP_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `KMP_ASSERT_NEXT(a_queue_keeps_item, clock, reset, q_valid && !q_ready, q_valid)

endmodule

/* rtl/core/kmp_back.sv */
// back end: kmp state update, position counter and result register
// depends on kmp_pkg; takes classified requests from kmp_front, chain masks from kmp_table_build
`include "kmp_stream_matcher_macros.svh"

module kmp_back #(
   parameter int MAX_PATTERN   = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_valid,
   output logic                                    q_ready,
   input  logic [MAX_PATTERN-1:0]                  q_eq,
   input  logic                                    q_last,
   input  logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] chain,
   input  logic [$clog2(MAX_PATTERN+1)-1:0]        eff_len,
   input  logic                                    cfg_clear,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output kmp_pkg::kmp_rsp_type                    rsp_payload
);
   import kmp_pkg::*;

   localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_BITS = $clog2(MAX_PATTERN + 1);

   logic [IDX_BITS-1:0]      partial_ff, partial_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   kmp_rsp_type              rsp_payload_ff;
   kmp_rsp_type              rsp_payload_in;

   logic                     pop;
   logic [MAX_PATTERN-1:0]   hit;
   logic [CNT_BITS-1:0]      advance;
   logic                     found;
   logic [POSITION_BITS-1:0] span;
   logic [POSITION_BITS-1:0] start_pos;
   logic [31:0]              start_wide;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign pop     = q_valid && q_ready;

   // candidates on the fallback chain that match the byte; the longest wins
   assign hit = chain[partial_ff] & q_eq;

   always_comb begin
      advance = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (hit[k]) begin
            advance = CNT_BITS'(k + 1);
         end
      end
   end

   assign found = (advance == eff_len);

   // start of the match, clamped at zero
   assign span       = POSITION_BITS'(eff_len - CNT_BITS'(1));
   assign start_pos  = (position_ff >= span) ? position_ff - span : '0;
   assign start_wide = 32'(start_pos);

   // next partial index and position
   always_comb begin
      partial_in  = partial_ff;
      position_in = position_ff;
      if (pop) begin
         partial_in = found ? '0 : advance[IDX_BITS-1:0];
         if (q_last) begin
            partial_in  = '0;
            position_in = '0;
         end else if (position_ff != '1) begin
            position_in = position_ff + POSITION_BITS'(1);
         end
      end
      if (cfg_clear) begin
         partial_in = '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (pop) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.match_found = found;
         rsp_payload_in.match_start = found ? start_wide[START_W-1:0] : '0;
         rsp_payload_in.result_last = q_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         position_ff  <= position_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `KMP_ASSERT_NEXT(a_match_restarts, clock, reset, pop && found, partial_ff == '0)
   `KMP_ASSERT_NEXT(a_pop_gives_result, clock, reset, pop, rsp_valid_ff)

endmodule

/* tb/kmp_stream_matcher_tb.sv */
// self-checking testbench for the streaming kmp matcher: drives text bytes and register
// writes, predicts every result and compares it field by field; depends on kmp_pkg and the rtl
`timescale 1ns / 100ps

module kmp_stream_matcher_tb;
   import kmp_pkg::*;

   localparam int MAX_PATTERN   = 8;
   localparam int POSITION_TOP  = (1 << START_W) - 1;
   localparam logic [3:0] NO_FALLBACK = 4'd15;
   localparam logic [CSR_ADDR_W-1:0] PATTERN_ADDR = {CSR_IDX_PATTERN, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] LENGTH_ADDR  = {CSR_IDX_LENGTH, 3'b000};
   localparam int CONFIG_GAP    = 20;
   localparam int HOLD_CYCLES   = 200;
   localparam int LONG_TEXT     = 30;
   localparam int PHASE_ITEMS   = 75;
   localparam int RANDOM_PHASES = 8;
   localparam int TIMEOUT_NS    = 500_000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   kmp_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   kmp_rsp_type           rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // text waiting to be sent and results the matcher still owes
   kmp_req_type pending_text[$];
   kmp_rsp_type awaited_results[$];

   // shadow copy of the matcher state
   logic [63:0] pattern_reg;
   logic [3:0]  length_reg;
   logic [3:0]  fallback_table [0:MAX_PATTERN-1];
   logic [3:0]  partial_len;
   int          text_pos;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_granted = 0;
   int hold_left = 0;
   int failures = 0;
   int results_checked = 0;
   int matches_seen = 0;
   int settings_used = 0;

   kmp_stream_matcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // length in use: zero counts as one, anything above the maximum as the maximum
   function automatic int used_length();
      int n;
      n = length_reg;
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
   endfunction

   function automatic logic [7:0] pattern_char(int k);
      return pattern_reg[8 * (k & 7) +: 8];
   endfunction

   // failure table of the active pattern prefix
   function automatic void rebuild_fallbacks();
      int n;
      int i;
      int j;
      int k;
      logic [3:0] f;
      n = used_length();
      i = 0;
      j = -1;
      for (k = 0; k < MAX_PATTERN; k++) fallback_table[k] = 4'd0;
      fallback_table[0] = NO_FALLBACK;
      while (i + 1 < n) begin
         if (j < 0 || pattern_char(i) == pattern_char(j)) begin
            i++;
            j++;
            fallback_table[i] = j[3:0];
         end else begin
            f = fallback_table[j];
            if (f == NO_FALLBACK) j = -1;
            else j = f;
         end
      end
   endfunction

   function automatic void reset_matcher_state();
      pattern_reg = '0;
      length_reg = 4'd1;
      partial_len = 4'd0;
      text_pos = 0;
      rebuild_fallbacks();
   endfunction

   // one kmp step for an accepted byte; queues the result it must produce
   function automatic void kmp_advance(kmp_req_type r);
      int n;
      int j;
      int guard;
      int start_at;
      logic [3:0] f;
      kmp_rsp_type res;
      res = '0;
      n = used_length();
      j = partial_len;
      if (j >= n) j = 0;
      for (guard = 0; guard <= MAX_PATTERN; guard++) begin
         if (j < 0 || r.text_byte == pattern_char(j)) break;
         f = fallback_table[j & 7];
         if (f == NO_FALLBACK) j = -1;
         else j = f;
      end
      if (j >= 0 && r.text_byte != pattern_char(j)) j = -1;
      j++;
      if (j >= n) begin
         res.match_found = 1'b1;
         j = 0;
         start_at = (text_pos >= n - 1) ? text_pos - (n - 1) : 0;
         res.match_start = start_at[START_W-1:0];
      end
      partial_len = j[3:0];
      if (r.text_last) begin
         text_pos = 0;
         partial_len = 4'd0;
      end else if (text_pos < POSITION_TOP) begin
         text_pos++;
      end
      res.result_last = r.text_last;
      awaited_results.push_back(res);
   endfunction

   // sender: offers queued text bytes, predicts each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) kmp_advance(req_payload);
         if (!req_valid || req_ready) begin
            if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_text.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result, stalls at random or for a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: found %0d start %0d last %0d",
                      rsp_payload.match_found, rsp_payload.match_start,
                      rsp_payload.result_last);
               failures++;
            end else begin
               kmp_rsp_type want;
               want = awaited_results.pop_front();
               results_checked++;
               if (rsp_payload.match_found) matches_seen++;
               if (rsp_payload.match_found !== want.match_found) begin
                  $error("match_found: expected %0d, got %0d",
                         want.match_found, rsp_payload.match_found);
                  failures++;
               end
               if (rsp_payload.match_start !== want.match_start) begin
                  $error("match_start: expected %0d, got %0d",
                         want.match_start, rsp_payload.match_start);
                  failures++;
               end
               if (rsp_payload.result_last !== want.result_last) begin
                  $error("result_last: expected %0d, got %0d",
                         want.result_last, rsp_payload.result_last);
                  failures++;
               end
            end
         end
         if (hold_asked != hold_granted) begin
            hold_granted <= hold_granted + 1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 48;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 48;
         end
         default: begin
            send_idle_pct = 37;
            recv_stall_pct = 37;
         end
      endcase
   endtask

   // wait until nothing is in flight, then let the table rebuild settle
   // sampled at the falling edge so the sender and receiver have settled
   task automatic wait_until_idle();
      while (pending_text.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
      repeat (CONFIG_GAP) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // shadow update: any write restarts the partial match
      if (addr == PATTERN_ADDR) pattern_reg = data;
      else length_reg = data[3:0];
      partial_len = 4'd0;
      rebuild_fallbacks();
   endtask

   task automatic configure(logic [63:0] pattern, logic [CSR_DATA_W-1:0] length_word);
      wait_until_idle();
      csr_write(PATTERN_ADDR, pattern);
      repeat (CONFIG_GAP) @(posedge clock);
      csr_write(LENGTH_ADDR, length_word);
      settings_used++;
   endtask

   task automatic push_text_byte(logic [7:0] ch, logic last);
      kmp_req_type item;
      item.text_byte = ch;
      item.text_last = last;
      pending_text.push_back(item);
   endtask

   task automatic queue_string(string s, bit close);
      int k;
      for (k = 0; k < s.len(); k++) push_text_byte(s[k], close && k == s.len() - 1);
   endtask

   function automatic logic [63:0] pack_pattern(string s);
      logic [63:0] p;
      int k;
      p = '0;
      for (k = 0; k < s.len() && k < MAX_PATTERN; k++) p[8 * k +: 8] = s[k];
      return p;
   endfunction

   // narrow patterns use a three-letter alphabet so fallbacks and matches are common
   function automatic logic [63:0] make_pattern(bit narrow);
      logic [63:0] p;
      int k;
      for (k = 0; k < MAX_PATTERN; k++)
         p[8 * k +: 8] = narrow ? 8'h61 + 8'($urandom_range(2)) : 8'($urandom_range(255));
      return p;
   endfunction

   // text mixing whole or partial pattern copies, pattern letters and arbitrary bytes
   task automatic queue_text(int count, bit close);
      int made;
      int cut;
      int k;
      int n;
      logic [7:0] ch;
      made = 0;
      n = used_length();
      while (made < count) begin
         if ($urandom_range(3) == 0) begin
            cut = ($urandom_range(2) == 0) ? $urandom_range(n, 1) : n;
            for (k = 0; k < cut && made < count; k++) begin
               push_text_byte(pattern_char(k), close && made == count - 1);
               made++;
            end
         end else begin
            if ($urandom_range(4) == 0) ch = 8'($urandom_range(255));
            else ch = pattern_char($urandom_range(n - 1));
            push_text_byte(ch, close && made == count - 1);
            made++;
         end
      end
   endtask

   initial begin
      int ph;
      int made;
      int len;
      int k;
      logic [CSR_DATA_W-1:0] length_word;

      reset_matcher_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset pattern is a single zero byte
      set_idling(IDLE_NONE);
      push_text_byte(8'h00, 1'b0);
      push_text_byte(8'hFF, 1'b0);
      push_text_byte(8'h00, 1'b1);

      // length zero acts as one
      configure({CSR_DATA_W{1'b1}}, '0);
      push_text_byte(8'hFF, 1'b0);
      push_text_byte(8'hFF, 1'b1);

      // length above the maximum acts as eight, with deep fallbacks
      configure(pack_pattern("aabaaaba"), 64'd15);
      queue_string("aabaaabaaaba", 1'b1);

      // register write in the middle of a text: partial match dropped, position kept
      queue_string("aaba", 1'b0);
      wait_until_idle();
      csr_write(LENGTH_ADDR, 64'd2);
      queue_string("aab", 1'b1);

      // random settings under every idling pattern
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         length_word = {$urandom, $urandom};
         if (ph == 0) length_word[3:0] = 4'd1;
         else if (ph == 1) length_word[3:0] = 4'd8;
         else if ($urandom_range(9) == 0) length_word[3:0] = 4'd0;
         else if ($urandom_range(9) == 0) length_word[3:0] = 4'($urandom_range(15, 9));
         else length_word[3:0] = 4'($urandom_range(8, 1));
         configure(make_pattern($urandom_range(3) != 0), length_word);
         set_idling(idle_mode_type'(ph % 4));
         // long receiver hold-off so the matcher backs up into its input
         if (ph == 4) hold_asked = hold_asked + 1;
         made = 0;
         while (made < PHASE_ITEMS) begin
            len = $urandom_range(30, 1);
            queue_text(len, $urandom_range(3) != 0);
            made += len;
         end
      end

      // dense two-letter text with many overlapping candidates
      configure(pack_pattern("aba"), 64'd3);
      set_idling(IDLE_NONE);
      for (k = 0; k < LONG_TEXT; k++) push_text_byte(8'h61 + 8'($urandom_range(1)),
                                                     k == LONG_TEXT - 1);
      queue_text(12, 1'b1);

      wait_until_idle();
      $display("checked %0d results with %0d matches over %0d pattern settings,",
               results_checked, matches_seen, settings_used);
      $display("all idling mixes, a long output hold-off and a %0d-byte two-letter text",
               LONG_TEXT);
      if (failures == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/kmp_pkg.sv
rtl/core/kmp_table_build.sv
rtl/core/kmp_front.sv
rtl/core/kmp_back.sv
rtl/core/kmp_stream_matcher.sv
tb/kmp_stream_matcher_tb.sv
